[rtl/core/cdt_pkg.sv]
// Types, codes and digit arithmetic shared by the countdown timer controller.
package cdt_pkg;

    // Event kinds carried in the input transaction.
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_ENC   = 2'd1,
        ACT_SHORT = 2'd2,
        ACT_LONG  = 2'd3
    } action_t;

    // Reported mode codes.
    typedef enum logic [1:0] {
        RUN_COUNT  = 2'd0,
        RUN_SETMIN = 2'd1,
        RUN_SETSEC = 2'd2,
        RUN_ALARM  = 2'd3
    } run_code_t;

    // Controller mode, one-hot.
    typedef enum logic [3:0] {
        ST_COUNT  = 4'b0001,
        ST_SETMIN = 4'b0010,
        ST_SETSEC = 4'b0100,
        ST_ALARM  = 4'b1000
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_HALF_PERIOD = 3'd0,
        CFG_SLEEP_TMO   = 3'd1,
        CFG_BEEP_TONE   = 3'd2,
        CFG_BEEP_PAUSE  = 3'd3,
        CFG_PRESET_MIN  = 3'd4
    } cfg_idx_t;

    localparam logic [7:0]  HALF_PERIOD_RST = 8'd50;
    localparam logic [11:0] SLEEP_TMO_RST   = 12'd3000;
    localparam logic [7:0]  BEEP_TONE_RST   = 8'd20;
    localparam logic [7:0]  BEEP_PAUSE_RST  = 8'd60;
    localparam logic [6:0]  PRESET_MAX      = 7'd99;
    localparam logic [2:0]  BEEP_LAST_PHASE = 3'd5;

    // MM:SS as BCD digits.
    typedef struct packed {
        logic [3:0] mt;
        logic [3:0] mo;
        logic [2:0] st;
        logic [3:0] so;
    } bcd_time_t;

    localparam bcd_time_t TIME_RST  = '{mt: 4'd0, mo: 4'd5, st: 3'd0, so: 4'd0};
    localparam bcd_time_t TIME_WRAP = '{mt: 4'd9, mo: 4'd9, st: 3'd0, so: 4'd0};

    function automatic logic time_zero(input bcd_time_t t);
        return (t.mt == 4'd0) && (t.mo == 4'd0) && (t.st == 3'd0) && (t.so == 4'd0);
    endfunction

    function automatic bcd_time_t min_up(input bcd_time_t t);
        bcd_time_t r;
        r = t;
        if (r.mo >= 4'd9) begin
            r.mo = 4'd0;
            if (r.mt >= 4'd9) begin
                r.mt = 4'd0;
                if ((r.so == 4'd0) && (r.st == 3'd0)) r.mo = 4'd1;
            end else begin
                r.mt = r.mt + 4'd1;
            end
        end else begin
            r.mo = r.mo + 4'd1;
        end
        return r;
    endfunction

    function automatic bcd_time_t sec_up(input bcd_time_t t);
        bcd_time_t r;
        r = t;
        if (r.so >= 4'd9) begin
            r.so = 4'd0;
            if (r.st >= 3'd5) begin
                r.st = 3'd0;
                r = min_up(r);
                if ((r.mt == 4'd0) && (r.mo == 4'd0)) r.so = 4'd1;
            end else begin
                r.st = r.st + 3'd1;
            end
        end else begin
            r.so = r.so + 4'd1;
        end
        return r;
    endfunction

    function automatic bcd_time_t min_down(input bcd_time_t t);
        bcd_time_t r;
        r = t;
        if (r.mo == 4'd0) begin
            r.mo = 4'd9;
            r.mt = (r.mt == 4'd0) ? 4'd9 : r.mt - 4'd1;
        end else begin
            r.mo = r.mo - 4'd1;
            if (time_zero(r)) r = TIME_WRAP;
        end
        return r;
    endfunction

    // counting = 1 lets the seconds reach 00:00 without wrapping.
    function automatic bcd_time_t sec_down(input bcd_time_t t, input logic counting);
        bcd_time_t r;
        r = t;
        if (r.so == 4'd0) begin
            r.so = 4'd9;
            if (r.st == 3'd0) begin
                r.st = 3'd5;
                r = min_down(r);
            end else begin
                r.st = r.st - 3'd1;
            end
        end else begin
            r.so = r.so - 4'd1;
            if (time_zero(r) && !counting) r = TIME_WRAP;
        end
        return r;
    endfunction

    // Saturate to 99 and split into tens and ones; 205/2048 is exact for values up to 99.
    function automatic logic [7:0] preset_digits(input logic [6:0] value);
        logic [6:0]  p;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        p    = (value > PRESET_MAX) ? PRESET_MAX : value;
        prod = {8'd0, p} * 15'd205;
        tens = prod[14:11];
        ones = p - 7'({tens, 3'b000} + {2'b00, tens, 1'b0});
        return {tens, ones[3:0]};
    endfunction

    function automatic run_code_t mode_code(input mode_t m);
        run_code_t c;
        case (m)
            ST_COUNT:  c = RUN_COUNT;
            ST_SETMIN: c = RUN_SETMIN;
            ST_SETSEC: c = RUN_SETSEC;
            ST_ALARM:  c = RUN_ALARM;
            default:   c = RUN_SETMIN;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/countdown_timer_controller_top.sv]
// Countdown kitchen timer controller: event register, state update and result register.
//
// Usage
//   Input stream (s_*): one transaction per event. s_tuser carries the event kind
//   (tick, encoder step, short press, long press), s_tdata[0] the encoder direction.
//   Result stream (m_*): exactly one transaction per event, the displayed time,
//   mode and indicator levels after that event, plus a click flag for encoder steps.
//   Config channel (cfg_*): always ready; index selects half period, sleep timeout,
//   beep tone, beep pause or preset minutes. Write only while no event is in flight.
// Timing
//   An accepted event lands in the event register. Once the result register can take a
//   new result, the event is applied to the timer state and its result is loaded into
//   the result register, which drives m_tvalid. The state update is a single short pass of
//   digit logic, so one event per cycle is sustained while m_tready stays high.
// Reset and back-pressure
//   aresetn (synchronous, active low) restores 05:00, set-minutes mode and the default
//   register values, and empties both registers. When m_tready is low the result
//   register holds, the event register fills, and s_tready drops only once both full.
module countdown_timer_controller_top
    import cdt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] turn_cw, [7:1] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] min_tens, [7:4] min_ones, [10:8] sec_tens, [14:11] sec_ones,
    // [16:15] run_mode, [17] colon_lit, [18] buzzer_on, [19] display_lit,
    // [20] asleep, [21] click_pulse, [23:22] zero
    output logic [23:0] m_tdata,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    // Configuration registers
    logic [7:0]  half_period_reg;
    logic [11:0] sleep_tmo_reg;
    logic [7:0]  beep_tone_reg;
    logic [7:0]  beep_pause_reg;
    logic [3:0]  preset_tens_reg;   // preset kept pre-split into BCD digits
    logic [3:0]  preset_ones_reg;
    logic [7:0]  preset_split;

    // Event register
    logic        in_valid_reg;
    action_t     in_action_reg;
    logic        in_right_reg;

    // Result register
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic [23:0] out_data_next;

    // Timer state
    mode_t       mode_reg,    mode_next;
    bcd_time_t   time_reg,    time_next;
    logic [7:0]  half_cnt_reg, half_cnt_next;
    logic [7:0]  beep_cnt_reg, beep_cnt_next;
    logic [11:0] idle_cnt_reg, idle_cnt_next;
    logic [1:0]  sec_div_reg,  sec_div_next;
    logic [2:0]  beep_phase_reg, beep_phase_next;
    logic        colon_reg,   colon_next;
    logic        buzzer_reg,  buzzer_next;
    logic        display_reg, display_next;
    logic        sleep_reg,   sleep_next;
    logic        click_next;
    logic        beep_on;

    logic        advance;   // result register can take a new result
    logic        process;   // event register content is applied this cycle

    assign advance   = !out_valid_reg || m_tready;
    assign process   = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign preset_split = preset_digits(cfg_data[6:0]);

    // ---------------------------------------------------------------
    // Next timer state for the event in the event register
    // ---------------------------------------------------------------
    always_comb begin
        mode_next       = mode_reg;
        time_next       = time_reg;
        half_cnt_next   = half_cnt_reg;
        beep_cnt_next   = beep_cnt_reg;
        idle_cnt_next   = idle_cnt_reg;
        sec_div_next    = sec_div_reg;
        beep_phase_next = beep_phase_reg;
        colon_next      = colon_reg;
        buzzer_next     = buzzer_reg;
        display_next    = display_reg;
        sleep_next      = sleep_reg;
        click_next      = 1'b0;
        beep_on         = 1'b0;

        case (in_action_reg)
            ACT_TICK: begin
                if (!sleep_reg) begin
                    if (half_cnt_next != 8'd0)  half_cnt_next = half_cnt_next - 8'd1;
                    if (beep_cnt_next != 8'd0)  beep_cnt_next = beep_cnt_next - 8'd1;
                    if (idle_cnt_next != 12'd0) idle_cnt_next = idle_cnt_next - 12'd1;
                    // half period: colon toggle, countdown on every second one
                    if (half_cnt_next == 8'd0) begin
                        half_cnt_next = half_period_reg;
                        colon_next    = ~colon_reg;
                        if (mode_next == ST_COUNT) begin
                            if (sec_div_next > 2'd1) begin
                                time_next    = sec_down(time_next, 1'b1);
                                sec_div_next = 2'd0;
                            end
                            if (time_zero(time_next)) begin
                                idle_cnt_next = sleep_tmo_reg;
                                mode_next     = ST_ALARM;
                            end
                            sec_div_next = sec_div_next + 2'd1;
                        end
                    end
                    // alarm pattern: beep, gap, beep, gap, beep, pause
                    if ((beep_cnt_next == 8'd0) && (mode_next == ST_ALARM)) begin
                        beep_on      = !beep_phase_reg[0] && (beep_phase_reg < BEEP_LAST_PHASE);
                        buzzer_next  = beep_on;
                        display_next = beep_on;
                        if (beep_phase_reg >= BEEP_LAST_PHASE) begin
                            beep_cnt_next   = beep_pause_reg;
                            beep_phase_next = 3'd0;
                        end else begin
                            beep_cnt_next   = beep_tone_reg;
                            beep_phase_next = beep_phase_reg + 3'd1;
                        end
                    end
                    if ((idle_cnt_next == 12'd0) && (mode_next != ST_COUNT)) begin
                        display_next = 1'b0;
                        sleep_next   = 1'b1;
                    end
                end
            end
            ACT_ENC: begin
                if (!sleep_reg) begin
                    click_next    = 1'b1;
                    idle_cnt_next = sleep_tmo_reg;
                    buzzer_next   = 1'b0;
                    if (mode_next == ST_ALARM) begin
                        mode_next    = ST_SETMIN;
                        display_next = 1'b1;
                    end
                    if (mode_next == ST_SETSEC) begin
                        time_next = in_right_reg ? sec_up(time_reg)
                                                 : sec_down(time_reg, 1'b0);
                    end else begin
                        time_next = in_right_reg ? min_up(time_reg) : min_down(time_reg);
                    end
                end
            end
            ACT_SHORT, ACT_LONG: begin
                // a press wakes the block, then acts as usual
                sleep_next    = 1'b0;
                if (sleep_reg) display_next = 1'b1;
                idle_cnt_next = sleep_tmo_reg;
                if (in_action_reg == ACT_SHORT) begin
                    case (mode_reg)
                        ST_COUNT, ST_ALARM: begin
                            mode_next    = ST_SETMIN;
                            buzzer_next  = 1'b0;
                            display_next = 1'b1;
                        end
                        ST_SETMIN: mode_next = ST_SETSEC;
                        default:   mode_next = ST_SETMIN;
                    endcase
                end else begin
                    case (mode_reg)
                        ST_COUNT: begin
                            mode_next    = ST_SETMIN;
                            buzzer_next  = 1'b0;
                            display_next = 1'b1;
                        end
                        ST_ALARM: begin
                            mode_next    = ST_SETMIN;
                            buzzer_next  = 1'b0;
                            display_next = 1'b1;
                            time_next    = '{mt: preset_tens_reg, mo: preset_ones_reg,
                                             st: 3'd0, so: 4'd0};
                        end
                        default: mode_next = ST_COUNT;
                    endcase
                end
            end
            default: ;
        endcase

        out_data_next = {2'b00, click_next, sleep_next, display_next, buzzer_next,
                         colon_next, mode_code(mode_next), time_next.so, time_next.st,
                         time_next.mo, time_next.mt};
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RST;
            sleep_tmo_reg   <= SLEEP_TMO_RST;
            beep_tone_reg   <= BEEP_TONE_RST;
            beep_pause_reg  <= BEEP_PAUSE_RST;
            preset_tens_reg <= TIME_RST.mt;
            preset_ones_reg <= TIME_RST.mo;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HALF_PERIOD: half_period_reg <= cfg_data[7:0];
                CFG_SLEEP_TMO:   sleep_tmo_reg   <= cfg_data;
                CFG_BEEP_TONE:   beep_tone_reg   <= cfg_data[7:0];
                CFG_BEEP_PAUSE:  beep_pause_reg  <= cfg_data[7:0];
                CFG_PRESET_MIN: begin
                    preset_tens_reg <= preset_split[7:4];
                    preset_ones_reg <= preset_split[3:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= action_t'(s_tuser);
            in_right_reg  <= s_tdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= ST_SETMIN;
            time_reg       <= TIME_RST;
            half_cnt_reg   <= 8'd0;
            beep_cnt_reg   <= 8'd0;
            idle_cnt_reg   <= SLEEP_TMO_RST;
            sec_div_reg    <= 2'd0;
            beep_phase_reg <= 3'd0;
            colon_reg      <= 1'b0;
            buzzer_reg     <= 1'b0;
            display_reg    <= 1'b1;
            sleep_reg      <= 1'b0;
        end else if (process) begin
            mode_reg       <= mode_next;
            time_reg       <= time_next;
            half_cnt_reg   <= half_cnt_next;
            beep_cnt_reg   <= beep_cnt_next;
            idle_cnt_reg   <= idle_cnt_next;
            sec_div_reg    <= sec_div_next;
            beep_phase_reg <= beep_phase_next;
            colon_reg      <= colon_next;
            buzzer_reg     <= buzzer_next;
            display_reg    <= display_next;
            sleep_reg      <= sleep_next;
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_sleep_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        sleep_reg |-> !display_reg)
        else $error("asleep with display lit");

    a_sleep_not_counting: assert property (@(posedge aclk) disable iff (!aresetn)
        sleep_reg |-> (mode_reg != ST_COUNT))
        else $error("asleep while counting down");

    a_buzzer_alarm_only: assert property (@(posedge aclk) disable iff (!aresetn)
        buzzer_reg |-> (mode_reg == ST_ALARM))
        else $error("buzzer driven outside alarm");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> out_valid_reg)
        else $error("processed event produced no result");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !process |=> ($stable(time_reg) && $stable(mode_reg)))
        else $error("timer state changed without an event");

endmodule

[sim/countdown_timer_controller_top_tb.sv]
// Self-checking testbench for the countdown timer controller: predictor, scoreboard, drivers.
`timescale 1ns / 1ps

import cdt_pkg::*;

// One result transaction as it sits on m_tdata, lowest field last.
typedef struct packed {
    logic [1:0] pad;
    logic       click;
    logic       asleep;
    logic       display;
    logic       buzzer;
    logic       colon;
    run_code_t  mode;
    logic [3:0] sec_ones;
    logic [2:0] sec_tens;
    logic [3:0] min_ones;
    logic [3:0] min_tens;
} timer_view_t;

typedef logic [3:0] view_fields_t [11];

// Mirrors the timer state per accepted event and checks each result against the oldest prediction.
class timer_scoreboard;
    // register copies
    logic [7:0]  half_period, tone_len, pause_len;
    logic [11:0] sleep_tmo;
    logic [6:0]  preset;
    // timer state
    run_code_t   mode;
    logic [3:0]  mt, mo, so;
    logic [2:0]  st;
    logic [7:0]  half_cnt, beep_cnt;
    logic [11:0] idle_cnt;
    logic [1:0]  sec_div;
    logic [2:0]  beep_ph;
    logic        colon, buzzer, display, asleep;

    timer_view_t pending [$];
    string       field_names [11];
    int unsigned errors, checked, alarms, sleeps;

    function new();
        half_period = HALF_PERIOD_RST;
        sleep_tmo   = SLEEP_TMO_RST;
        tone_len    = BEEP_TONE_RST;
        pause_len   = BEEP_PAUSE_RST;
        preset      = 7'd5;
        mode        = RUN_SETMIN;
        load_time(4'd0, 4'd5, 3'd0, 4'd0);
        half_cnt    = 8'd0;
        beep_cnt    = 8'd0;
        idle_cnt    = SLEEP_TMO_RST;
        sec_div     = 2'd0;
        beep_ph     = 3'd0;
        colon       = 1'b0;
        buzzer      = 1'b0;
        display     = 1'b1;
        asleep      = 1'b0;
        errors      = 0;
        checked     = 0;
        alarms      = 0;
        sleeps      = 0;
        field_names = '{"min_tens", "min_ones", "sec_tens", "sec_ones", "run_mode",
                        "colon_lit", "buzzer_on", "display_lit", "asleep", "click_pulse",
                        "pad"};
    endfunction

    function void set_reg(cfg_idx_t idx, logic [11:0] val);
        case (idx)
            CFG_HALF_PERIOD: half_period = val[7:0];
            CFG_SLEEP_TMO:   sleep_tmo   = val;
            CFG_BEEP_TONE:   tone_len    = val[7:0];
            CFG_BEEP_PAUSE:  pause_len   = val[7:0];
            CFG_PRESET_MIN:  preset      = val[6:0];
            default: ;
        endcase
    endfunction

    function void load_time(logic [3:0] a, logic [3:0] b, logic [2:0] c, logic [3:0] d);
        mt = a;
        mo = b;
        st = c;
        so = d;
    endfunction

    function logic at_zero();
        return (mt == 4'd0) && (mo == 4'd0) && (st == 3'd0) && (so == 4'd0);
    endfunction

    function int unsigned minutes();
        return int'(mt) * 10 + int'(mo);
    endfunction

    function int unsigned seconds();
        return int'(st) * 10 + int'(so);
    endfunction

    // 99 -> 00 carries into 01 when the seconds are zero, so 00:00 never appears
    function void minute_inc();
        if (mo >= 4'd9) begin
            mo = 4'd0;
            if (mt >= 4'd9) begin
                mt = 4'd0;
                if (so == 4'd0 && st == 3'd0) mo = 4'd1;
            end else begin
                mt = mt + 4'd1;
            end
        end else begin
            mo = mo + 4'd1;
        end
    endfunction

    function void second_inc();
        if (so >= 4'd9) begin
            so = 4'd0;
            if (st >= 3'd5) begin
                st = 3'd0;
                minute_inc();
                if (mt == 4'd0 && mo == 4'd0) so = 4'd1;
            end else begin
                st = st + 3'd1;
            end
        end else begin
            so = so + 4'd1;
        end
    endfunction

    function void minute_dec();
        if (mo == 4'd0) begin
            mo = 4'd9;
            mt = (mt == 4'd0) ? 4'd9 : mt - 4'd1;
        end else begin
            mo = mo - 4'd1;
            if (at_zero()) load_time(4'd9, 4'd9, 3'd0, 4'd0);
        end
    endfunction

    // counting may land on 00:00; setting jumps to 99:00 instead
    function void second_dec();
        if (so == 4'd0) begin
            so = 4'd9;
            if (st == 3'd0) begin
                st = 3'd5;
                minute_dec();
            end else begin
                st = st - 3'd1;
            end
        end else begin
            so = so - 4'd1;
            if (at_zero() && mode != RUN_COUNT) load_time(4'd9, 4'd9, 3'd0, 4'd0);
        end
    endfunction

    function void half_step();
        if (sec_div > 2'd1) begin
            second_dec();
            sec_div = 2'd0;
        end
        if (at_zero()) begin
            idle_cnt = sleep_tmo;
            mode     = RUN_ALARM;
            alarms++;
        end
        sec_div = sec_div + 2'd1;
    endfunction

    // three beeps with the display blinking, then a pause
    function void beep_step();
        logic on;
        on      = (beep_ph[0] == 1'b0) && (beep_ph < 3'd5);
        buzzer  = on;
        display = on;
        if (beep_ph >= 3'd5) begin
            beep_cnt = pause_len;
            beep_ph  = 3'd0;
        end else begin
            beep_cnt = tone_len;
            beep_ph  = beep_ph + 3'd1;
        end
    endfunction

    function void back_to_setting();
        mode    = RUN_SETMIN;
        buzzer  = 1'b0;
        display = 1'b1;
    endfunction

    function void tick();
        if (half_cnt != 8'd0) half_cnt = half_cnt - 8'd1;
        if (beep_cnt != 8'd0) beep_cnt = beep_cnt - 8'd1;
        if (idle_cnt != 12'd0) idle_cnt = idle_cnt - 12'd1;
        if (half_cnt == 8'd0) begin
            half_cnt = half_period;
            colon    = ~colon;
            if (mode == RUN_COUNT) half_step();
        end
        if (beep_cnt == 8'd0 && mode == RUN_ALARM) beep_step();
        if (idle_cnt == 12'd0 && mode != RUN_COUNT) begin
            display = 1'b0;
            asleep  = 1'b1;
            sleeps++;
        end
    endfunction

    function void encoder_step(logic right);
        idle_cnt = sleep_tmo;
        buzzer   = 1'b0;
        if (mode == RUN_ALARM) begin
            mode    = RUN_SETMIN;
            display = 1'b1;
        end
        if (mode == RUN_SETMIN || mode == RUN_COUNT) begin
            if (right) minute_inc(); else minute_dec();
        end else if (mode == RUN_SETSEC) begin
            if (right) second_inc(); else second_dec();
        end
    endfunction

    function void short_press();
        idle_cnt = sleep_tmo;
        if (mode == RUN_COUNT || mode == RUN_ALARM) back_to_setting();
        else if (mode == RUN_SETMIN) mode = RUN_SETSEC;
        else mode = RUN_SETMIN;
    endfunction

    function void long_press();
        logic [6:0] p;
        idle_cnt = sleep_tmo;
        if (mode == RUN_COUNT) begin
            back_to_setting();
        end else if (mode == RUN_ALARM) begin
            p = (preset > 7'd99) ? 7'd99 : preset;
            back_to_setting();
            load_time(4'(p / 7'd10), 4'(p % 7'd10), 3'd0, 4'd0);
        end else begin
            mode = RUN_COUNT;
        end
    endfunction

    // Applies one accepted event and queues the view it should produce.
    function void note_event(action_t act, logic right);
        timer_view_t v;
        logic        click;
        click = 1'b0;
        case (act)
            ACT_TICK: if (!asleep) tick();
            ACT_ENC: begin
                if (!asleep) begin
                    encoder_step(right);
                    click = 1'b1;
                end
            end
            default: begin
                if (asleep) begin
                    asleep   = 1'b0;
                    display  = 1'b1;
                    idle_cnt = sleep_tmo;
                end
                if (act == ACT_SHORT) short_press(); else long_press();
            end
        endcase
        v          = '0;
        v.min_tens = mt;
        v.min_ones = mo;
        v.sec_tens = st;
        v.sec_ones = so;
        v.mode     = mode;
        v.colon    = colon;
        v.buzzer   = buzzer;
        v.display  = display;
        v.asleep   = asleep;
        v.click    = click;
        pending.push_back(v);
    endfunction

    function view_fields_t fields_of(timer_view_t v);
        view_fields_t f;
        f[0]  = v.min_tens;
        f[1]  = v.min_ones;
        f[2]  = {1'b0, v.sec_tens};
        f[3]  = v.sec_ones;
        f[4]  = {2'b0, v.mode};
        f[5]  = {3'b0, v.colon};
        f[6]  = {3'b0, v.buzzer};
        f[7]  = {3'b0, v.display};
        f[8]  = {3'b0, v.asleep};
        f[9]  = {3'b0, v.click};
        f[10] = {2'b0, v.pad};
        return f;
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_view(logic [23:0] raw);
        timer_view_t  want;
        view_fields_t got_f, want_f;
        if (pending.size() == 0) begin
            report($sformatf("result %h with no event outstanding", raw));
            return;
        end
        want   = pending.pop_front();
        got_f  = fields_of(timer_view_t'(raw));
        want_f = fields_of(want);
        for (int i = 0; i < 11; i++) begin
            if (got_f[i] !== want_f[i])
                report($sformatf("result %0d: %s is %0d, expected %0d",
                                 checked, field_names[i], got_f[i], want_f[i]));
        end
        checked++;
    endtask
endclass

module countdown_timer_controller_top_tb;

    localparam int unsigned IDLE_PCT   = 36;        // per-cycle chance of a bubble or stall
    localparam int unsigned LATENCY    = 2;         // event register plus result register
    localparam int unsigned TIMEOUT_NS = 5_000_000; // far beyond the slowest legal run
    localparam int unsigned NUM_PHASES = 9;

    // one register setting and how many events to run under it
    typedef struct {
        logic [7:0]  half_period;
        logic [11:0] sleep_tmo;
        logic [7:0]  tone_len;
        logic [7:0]  pause_len;
        logic [6:0]  preset;
        int unsigned quota;
        bit          calm;   // no bubbles or stalls on either side
    } setting_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data  = '0;

    timer_scoreboard sb;
    setting_t        plan [NUM_PHASES];
    bit              idling_on = 1'b1;
    int unsigned     events_sent, ignored_sent, budget_end;

    countdown_timer_controller_top dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    // Result side: check every accepted transaction, then decide whether to stall the next cycle.
    initial begin
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_view(m_tdata);
            m_tready <= !(idling_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Offers one event, with random bubbles ahead of it, and notes it once accepted.
    // Ticks and encoder steps while asleep are still sent but not counted as real work.
    task automatic send_event(action_t act, logic right);
        bit ignored;
        ignored = sb.asleep && (act == ACT_TICK || act == ACT_ENC);
        while (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, right};
        do @(posedge aclk); while (!s_tready);
        sb.note_event(act, right);
        if (ignored) ignored_sent++; else events_sent++;
    endtask

    // True while the current phase still has events to spend.
    function automatic bit budget_left();
        return (events_sent + ignored_sent) < budget_end;
    endfunction

    // Occasional stray event to break up the well-formed sequences.
    task automatic maybe_noise(int unsigned pct);
        if ($urandom_range(0, 99) < pct)
            send_event(action_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    // Stop sending and wait until every outstanding result has been checked.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_setting(setting_t s);
        write_reg(CFG_HALF_PERIOD, {4'd0, s.half_period});
        write_reg(CFG_SLEEP_TMO, s.sleep_tmo);
        write_reg(CFG_BEEP_TONE, {4'd0, s.tone_len});
        write_reg(CFG_BEEP_PAUSE, {4'd0, s.pause_len});
        write_reg(CFG_PRESET_MIN, {5'd0, s.preset});
        cfg_valid <= 1'b0;
    endtask

    // One user session: dial in a short time, count it down into the alarm, let it beep,
    // silence it and sometimes leave the unit alone until it sleeps. The predictor's state
    // steers each step, so stray events just cost a few extra steps.
    task automatic play_session();
        int unsigned tgt_min, tgt_sec, guard;
        logic        up;
        if (sb.asleep || sb.mode == RUN_COUNT || sb.mode == RUN_ALARM)
            send_event($urandom_range(0, 1) ? ACT_SHORT : ACT_LONG, 1'($urandom_range(0, 1)));
        tgt_min = ($urandom_range(0, 3) == 0) ? 1 : 0;
        tgt_sec = $urandom_range(1, 20);

        // seconds first: with them nonzero the minutes can be taken to 00 without a wrap
        guard = 0;
        while (budget_left() && guard < 80 &&
               !(sb.mode == RUN_SETSEC && !sb.asleep && sb.seconds() == tgt_sec)) begin
            if (sb.asleep || sb.mode != RUN_SETSEC)
                send_event(ACT_SHORT, 1'($urandom_range(0, 1)));
            else
                send_event(ACT_ENC, sb.seconds() < tgt_sec);
            maybe_noise(8);
            guard++;
        end

        // minutes, turning whichever way round the dial is shorter
        guard = 0;
        while (budget_left() && guard < 80 &&
               !(sb.mode == RUN_SETMIN && !sb.asleep && sb.minutes() == tgt_min)) begin
            if (sb.asleep || sb.mode != RUN_SETMIN) begin
                send_event(ACT_SHORT, 1'($urandom_range(0, 1)));
            end else begin
                up = ((tgt_min + 100 - sb.minutes()) % 100) <= 50;
                send_event(ACT_ENC, up);
            end
            maybe_noise(8);
            guard++;
        end

        // start and count down
        send_event(ACT_LONG, 1'($urandom_range(0, 1)));
        guard = 0;
        while (budget_left() && sb.mode == RUN_COUNT && guard < 400) begin
            send_event(ACT_TICK, 1'($urandom_range(0, 1)));
            maybe_noise(3);
            guard++;
        end

        // let the beep pattern run a while, then silence it by any of the three inputs
        guard = $urandom_range(0, 60);
        while (budget_left() && sb.mode == RUN_ALARM && guard > 0) begin
            send_event(ACT_TICK, 1'($urandom_range(0, 1)));
            guard--;
        end
        if (sb.mode == RUN_ALARM)
            send_event(action_t'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));

        // sometimes wait for the idle timeout, then poke the sleeping unit
        if ($urandom_range(0, 1) == 1) begin
            guard = 0;
            while (budget_left() && !sb.asleep && sb.mode != RUN_COUNT && guard < 300) begin
                send_event(ACT_TICK, 1'($urandom_range(0, 1)));
                guard++;
            end
            repeat ($urandom_range(0, 3))
                send_event(action_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        sb = new();

        plan[0] = '{8'd1, 12'd1, 8'd1, 8'd1, 7'd1, 150, 1'b0};           // lowest legal values
        plan[1] = '{8'd255, 12'd4095, 8'd255, 8'd255, 7'd99, 80, 1'b0};  // highest legal values
        plan[2] = '{8'd0, 12'd0, 8'd0, 8'd0, 7'd127, 100, 1'b0};         // zero lengths, preset saturates
        plan[3] = '{8'd2, 12'd30, 8'd0, 8'd3, 7'd0, 100, 1'b0};          // preset of zero minutes
        for (int i = 4; i < NUM_PHASES; i++)
            plan[i] = '{8'($urandom_range(1, 3)), 12'($urandom_range(8, 80)),
                        8'($urandom_range(1, 4)), 8'($urandom_range(1, 10)),
                        7'($urandom_range(1, 99)), 120, i == 4};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening at reset values, from 05:00 in set-minutes mode.
        send_event(ACT_TICK, 1'b0);          // first tick toggles the colon
        repeat (5) send_event(ACT_ENC, 1'b0); // down to 01:00, then decrement to zero gives 99:00
        send_event(ACT_ENC, 1'b1);           // 99 up skips 00:00 and gives 01:00
        send_event(ACT_SHORT, 1'b0);         // set seconds
        send_event(ACT_ENC, 1'b0);           // borrow into the minutes: 00:59
        send_event(ACT_ENC, 1'b1);           // carry back: 01:00
        send_event(ACT_ENC, 1'b0);
        send_event(ACT_LONG, 1'b1);          // start counting from set seconds
        send_event(ACT_ENC, 1'b1);           // encoder adjusts minutes while counting
        send_event(ACT_ENC, 1'b0);
        send_event(ACT_TICK, 1'b1);
        send_event(ACT_SHORT, 1'b1);         // short press stops counting
        send_event(ACT_SHORT, 1'b0);
        send_event(ACT_SHORT, 1'b1);         // set seconds back to set minutes
        send_event(ACT_LONG, 1'b0);          // start from set minutes
        send_event(ACT_LONG, 1'b1);          // long press stops counting
        settle();

        // Random sessions under each register setting; the block is idle at each write.
        for (int p = 0; p < NUM_PHASES; p++) begin
            apply_setting(plan[p]);
            idling_on  = !plan[p].calm;
            budget_end = events_sent + ignored_sent + plan[p].quota;
            while (budget_left()) play_session();
            settle();
        end

        $display("Ran %0d events (+%0d ignored while asleep) over %0d register settings",
                 events_sent, ignored_sent, NUM_PHASES + 1);
        $display("%0d results checked, alarm reached %0d times, sleep entered %0d times",
                 sb.checked, sb.alarms, sb.sleeps);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
